[rtl/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, defaults and component codes for the rotation matrix to
// quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // Width of every matrix entry and quaternion component.
    localparam int DATA_W = 16;

    // Default number of fraction bits.
    localparam int FRAC_BITS_DEF = 14;

    // Width of an exact sum or difference of two entries.
    localparam int NUM_W = DATA_W + 1;

    // Quotient bits that are resolved before saturation is decided.
    localparam int QUO_BITS = DATA_W + 1;

    // Component codes: which quaternion component comes from the root.
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;
    localparam logic [1:0] COMP_W = 2'd3;

endpackage

[rtl/rmq_mat_if.sv]
// ----------------------------------------------------------------------------
// rmq_mat_if
// Channel that carries one 3x3 matrix item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmq_mat_if
    import rmq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] m00;
    logic signed [DATA_W-1:0] m01;
    logic signed [DATA_W-1:0] m02;
    logic signed [DATA_W-1:0] m10;
    logic signed [DATA_W-1:0] m11;
    logic signed [DATA_W-1:0] m12;
    logic signed [DATA_W-1:0] m20;
    logic signed [DATA_W-1:0] m21;
    logic signed [DATA_W-1:0] m22;

    modport source (
        output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
        input  ready
    );

    modport sink (
        input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
        output ready
    );
endinterface

[rtl/rmq_quat_if.sv]
// ----------------------------------------------------------------------------
// rmq_quat_if
// Channel that carries one quaternion item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmq_quat_if
    import rmq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] quat_x;
    logic signed [DATA_W-1:0] quat_y;
    logic signed [DATA_W-1:0] quat_z;
    logic signed [DATA_W-1:0] quat_w;
    logic                     degenerate;

    modport source (
        output valid, quat_x, quat_y, quat_z, quat_w, degenerate,
        input  ready
    );

    modport sink (
        input  valid, quat_x, quat_y, quat_z, quat_w, degenerate,
        output ready
    );
endinterface

[rtl/rotation_matrix_to_quaternion.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a fixed-point rotation matrix to a unit quaternion.
// ----------------------------------------------------------------------------
// The block takes one matrix item per cycle while the pipeline is not stalled
// and returns one quaternion item per matrix, in order. Its stages, where S_W
// is ((FRAC_BITS + 2 >= 19 ? FRAC_BITS + 2 : 19) - 1 + FRAC_BITS + 1) / 2, are:
// one stage forms the radicand and numerators, S_W stages resolve one root bit
// each, one stage checks quotient overflow, seventeen stages resolve one
// quotient bit each for the three divided components in parallel, and the
// output register saturates and places the components. Each stage holds its
// item when the next one is full and cannot move on, so a stall at the output
// fills the bubbles first and no item is lost or repeated. A non-positive
// radicand gives zero components and raises degenerate.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rmq_mat_if.sink    in_ch,
    rmq_quat_if.source out_ch
);

    // Widths derived from the fraction bits.
    localparam int RAD_W  = (FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19;
    localparam int V_W    = RAD_W - 1 + FRAC_BITS;
    localparam int S_W    = (V_W + 1) / 2;
    localparam int REM_W  = V_W + 2;
    localparam int DV_W   = FRAC_BITS + S_W + QUO_BITS + 2;
    localparam int SQ_N   = S_W;
    localparam int DIV_N  = QUO_BITS + 1;
    localparam int N_STG  = 1 + SQ_N + DIV_N + 1;

    typedef logic signed [NUM_W-1:0] num_t;

    // Payload of the square root stages.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [S_W-1:0]   root;
        num_t [2:0]       nums;
        logic [1:0]       main;
        logic             degen;
    } sq_t;

    // One divider lane.
    typedef struct packed {
        logic [DV_W-1:0]     rem;
        logic [QUO_BITS-1:0] quo;
        logic                ovf;
        logic                neg;
    } lane_t;

    // Payload of the divider stages.
    typedef struct packed {
        lane_t [2:0]    lanes;
        logic [S_W-1:0] root;
        logic [1:0]     main;
        logic           degen;
    } dv_t;

    // Handshake chain: a stage may load when it is empty or moves on.
    logic [N_STG-1:0] valid_reg;
    logic [N_STG-1:0] valid_src;
    logic [N_STG:0]   adv;

    always_comb
    begin
        adv[N_STG] = out_ch.ready;
        for (int i = N_STG - 1; i >= 0; i--)
        begin
            adv[i] = ~valid_reg[i] | adv[i+1];
        end
    end

    assign in_ch.ready = adv[0];

    // Each stage takes its valid bit from the stage before it.
    assign valid_src = {valid_reg[N_STG-2:0], in_ch.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < N_STG; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_src[i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Front stage: axis choice, radicand and numerators.
    // ------------------------------------------------------------------
    sq_t front_next;
    sq_t front_reg;

    always_comb
    begin
        logic signed [RAD_W-1:0] e00, e11, e22, one, trace, rad;
        num_t n0, n1, n2, n3;
        logic [1:0] main;

        e00   = RAD_W'(in_ch.m00);
        e11   = RAD_W'(in_ch.m11);
        e22   = RAD_W'(in_ch.m22);
        one   = RAD_W'(1) <<< FRAC_BITS;
        trace = e00 + e11 + e22;
        n0 = '0;
        n1 = '0;
        n2 = '0;
        n3 = '0;

        if (trace > 0)
        begin
            main = COMP_W;
            rad  = trace + one;
            n0   = NUM_W'(in_ch.m21) - NUM_W'(in_ch.m12);
            n1   = NUM_W'(in_ch.m02) - NUM_W'(in_ch.m20);
            n2   = NUM_W'(in_ch.m10) - NUM_W'(in_ch.m01);
        end
        else
        begin
            if (in_ch.m00 < in_ch.m11)
            begin
                main = (in_ch.m11 < in_ch.m22) ? COMP_Z : COMP_Y;
            end
            else
            begin
                main = (in_ch.m00 < in_ch.m22) ? COMP_Z : COMP_X;
            end
            case (main)
                COMP_X:
                begin
                    rad = e00 - e11 - e22 + one;
                    n3  = NUM_W'(in_ch.m21) - NUM_W'(in_ch.m12);
                    n1  = NUM_W'(in_ch.m10) + NUM_W'(in_ch.m01);
                    n2  = NUM_W'(in_ch.m20) + NUM_W'(in_ch.m02);
                end
                COMP_Y:
                begin
                    rad = e11 - e22 - e00 + one;
                    n3  = NUM_W'(in_ch.m02) - NUM_W'(in_ch.m20);
                    n2  = NUM_W'(in_ch.m21) + NUM_W'(in_ch.m12);
                    n0  = NUM_W'(in_ch.m01) + NUM_W'(in_ch.m10);
                end
                default:
                begin
                    rad = e22 - e00 - e11 + one;
                    n3  = NUM_W'(in_ch.m10) - NUM_W'(in_ch.m01);
                    n0  = NUM_W'(in_ch.m02) + NUM_W'(in_ch.m20);
                    n1  = NUM_W'(in_ch.m12) + NUM_W'(in_ch.m21);
                end
            endcase
        end

        front_next.main  = main;
        front_next.degen = (rad <= 0);
        front_next.root  = '0;
        if (rad <= 0)
        begin
            front_next.rem = '0;
        end
        else
        begin
            front_next.rem = REM_W'(rad[RAD_W-2:0]) << FRAC_BITS;
        end

        // Lanes carry the three divided components in ascending order.
        front_next.nums[0] = (main == COMP_X) ? n1 : n0;
        front_next.nums[1] = (main == COMP_X || main == COMP_Y) ? n2 : n1;
        front_next.nums[2] = (main == COMP_W) ? n2 : n3;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            front_reg <= front_next;
        end
    end

    // ------------------------------------------------------------------
    // Square root: one root bit per stage, most significant first.
    // ------------------------------------------------------------------
    sq_t sq_reg [SQ_N];

    for (genvar g = 0; g < SQ_N; g++)
    begin : g_sqrt
        localparam int B = S_W - 1 - g;
        sq_t prev;
        sq_t sq_next;

        assign prev = (g == 0) ? front_reg : sq_reg[(g == 0) ? 0 : g - 1];

        always_comb
        begin
            logic [REM_W-1:0] trial;
            trial   = (REM_W'(prev.root) << (B + 1)) + (REM_W'(1) << (2 * B));
            sq_next = prev;
            if (prev.rem >= trial)
            begin
                sq_next.rem  = prev.rem - trial;
                sq_next.root = prev.root | (S_W'(1) << B);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[1 + g])
            begin
                sq_reg[g] <= sq_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider entry: magnitudes, signs and the quotient overflow check.
    // ------------------------------------------------------------------
    dv_t dv_reg [DIV_N];
    dv_t dv0_next;

    always_comb
    begin
        sq_t last;
        logic [NUM_W-1:0] mag;
        logic [DV_W-1:0]  dvd;
        last           = sq_reg[SQ_N-1];
        dv0_next.root  = last.root;
        dv0_next.main  = last.main;
        dv0_next.degen = last.degen;
        for (int l = 0; l < 3; l++)
        begin
            dv0_next.lanes[l].neg = last.nums[l][NUM_W-1];
            mag = last.nums[l][NUM_W-1] ? NUM_W'(-last.nums[l]) : NUM_W'(last.nums[l]);
            dvd = DV_W'(mag) << (FRAC_BITS - 1);
            dv0_next.lanes[l].rem = dvd;
            dv0_next.lanes[l].quo = '0;
            dv0_next.lanes[l].ovf = (dvd >= (DV_W'(last.root) << QUO_BITS));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1 + SQ_N])
        begin
            dv_reg[0] <= dv0_next;
        end
    end

    // Divider: one quotient bit per stage in all three lanes.
    for (genvar g = 1; g < DIV_N; g++)
    begin : g_div
        localparam int B = QUO_BITS - g;
        dv_t dv_next;

        always_comb
        begin
            logic [DV_W-1:0] trial;
            dv_next = dv_reg[g-1];
            trial   = DV_W'(dv_reg[g-1].root) << B;
            for (int l = 0; l < 3; l++)
            begin
                if (dv_reg[g-1].lanes[l].rem >= trial)
                begin
                    dv_next.lanes[l].rem = dv_reg[g-1].lanes[l].rem - trial;
                    dv_next.lanes[l].quo = dv_reg[g-1].lanes[l].quo | (QUO_BITS'(1) << B);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[1 + SQ_N + g])
            begin
                dv_reg[g] <= dv_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: saturation and placement of the components.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic                     degen_reg;

    always_ff @(posedge clk)
    begin
        dv_t fin;
        logic signed [DATA_W-1:0] mval;
        logic signed [DATA_W-1:0] lval [3];
        fin = dv_reg[DIV_N-1];

        if (32'(fin.root >> 1) > 32'd32767)
        begin
            mval = 16'sh7FFF;
        end
        else
        begin
            mval = DATA_W'(fin.root >> 1);
        end

        for (int l = 0; l < 3; l++)
        begin
            if (fin.lanes[l].neg)
            begin
                if (fin.lanes[l].ovf || fin.lanes[l].quo > QUO_BITS'(32768))
                begin
                    lval[l] = 16'sh8000;
                end
                else
                begin
                    lval[l] = DATA_W'(~fin.lanes[l].quo + QUO_BITS'(1));
                end
            end
            else
            begin
                if (fin.lanes[l].ovf || fin.lanes[l].quo > QUO_BITS'(32767))
                begin
                    lval[l] = 16'sh7FFF;
                end
                else
                begin
                    lval[l] = DATA_W'(fin.lanes[l].quo);
                end
            end
        end

        if (adv[N_STG-1])
        begin
            degen_reg <= fin.degen;
            if (fin.degen)
            begin
                qx_reg <= '0;
                qy_reg <= '0;
                qz_reg <= '0;
                qw_reg <= '0;
            end
            else
            begin
                qx_reg <= (fin.main == COMP_X) ? mval : lval[0];
                qy_reg <= (fin.main == COMP_Y) ? mval :
                          ((fin.main == COMP_X) ? lval[0] : lval[1]);
                qz_reg <= (fin.main == COMP_Z) ? mval :
                          ((fin.main == COMP_W) ? lval[2] : lval[1]);
                qw_reg <= (fin.main == COMP_W) ? mval : lval[2];
            end
        end
    end

    assign out_ch.valid      = valid_reg[N_STG-1];
    assign out_ch.quat_x     = qx_reg;
    assign out_ch.quat_y     = qy_reg;
    assign out_ch.quat_z     = qz_reg;
    assign out_ch.quat_w     = qw_reg;
    assign out_ch.degenerate = degen_reg;

endmodule
